>>> design/sfr_pkg.sv
// Package for the serial frame receiver: framing constants, phase and
// result-kind codes, and the result item type. No dependencies.
package sfr_pkg;

  localparam logic [7:0] CRC_POLY   = 8'h91;
  localparam logic [7:0] START_MARK = 8'h5c;
  localparam logic [7:0] ACK_BAD    = 8'h5d;
  localparam logic [7:0] ACK_GOOD   = 8'h5e;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_TYPE    = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
    logic [7:0] ack_byte;
    logic       last;
  } out_item_t;

endpackage

>>> design/sfr_in_if.sv
// Input channel of the serial frame receiver: one received byte per transfer.
// Valid/ready handshake; no package dependency.
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       rx_error;

  modport source (output valid, rx_byte, rx_error, input ready);
  modport sink   (input valid, rx_byte, rx_error, output ready);
endinterface

>>> design/sfr_out_if.sv
// Result channel of the serial frame receiver: payload bytes and verdicts.
// Valid/ready handshake; no package dependency.
interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [7:0] frame_type;
  logic [7:0] frame_length;
  logic [7:0] ack_byte;
  logic       last;

  modport source (output valid, kind, data_byte, frame_type, frame_length, ack_byte, last,
                  input ready);
  modport sink   (input valid, kind, data_byte, frame_type, frame_length, ack_byte, last,
                  output ready);
endinterface

>>> design/serial_frame_receiver_crc8.sv
// Top level of the serial frame receiver with reflected CRC-8 check.
// Depends on sfr_pkg, sfr_in_if, sfr_out_if, sfr_deframer and sfr_out_buf.
//
// Channel rx carries one received byte per transfer, with rx_error flagging
// a receive fault; a fault drops the byte and sends the block back to
// hunting for the start marker 0x5c. Channel frames carries the results:
// one item for each payload byte (kind 0, the byte in data_byte) and one
// verdict item after the check byte (kind 1 with ack 0x5e when the CRC
// matches, kind 2 with ack 0x5d otherwise, last set). Marker, type and
// length bytes give no result.
// Each byte is handled in the cycle it is taken; its result is registered in
// the result register, or in the skid entry while that is held. One byte per
// cycle is sustained while the skid entry is empty; the CRC update is combinational.
// A result register plus one skid entry sit before frames: when the
// receiver stalls, rx stays ready until the skid entry is filled too, then
// drops ready until a result is taken.
// Reset (synchronous, active high) empties both result entries and returns
// the block to hunting with cleared type, length, count and CRC.
module serial_frame_receiver_crc8 import sfr_pkg::*; (
  input  logic clk,
  input  logic rst,
  sfr_in_if.sink    rx,
  sfr_out_if.source frames
);

  logic      accept;
  logic      res_valid;
  out_item_t res_item;
  logic      buf_ready;

  assign rx.ready = buf_ready;
  assign accept   = rx.valid && rx.ready;

  sfr_deframer u_deframer (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx.rx_byte),
    .rx_error  (rx.rx_error),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  sfr_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (res_valid),
    .in_item  (res_item),
    .in_ready (buf_ready),
    .res      (frames)
  );

  // Input back-pressure only arises while a result is waiting.
  assert property (@(posedge clk) disable iff (rst) !rx.ready |-> frames.valid)
    else $error("rx stalled with no pending result");

  // Only verdict items end a frame.
  assert property (@(posedge clk) disable iff (rst)
      frames.valid |-> (frames.last == (frames.kind != KIND_PAYLOAD)))
    else $error("last flag disagrees with result kind");

  // The acknowledge byte follows the verdict.
  assert property (@(posedge clk) disable iff (rst)
      frames.valid |-> ((frames.kind == KIND_GOOD && frames.ack_byte == ACK_GOOD)
                     || (frames.kind == KIND_BAD && frames.ack_byte == ACK_BAD)
                     || (frames.kind == KIND_PAYLOAD && frames.ack_byte == 8'd0)))
    else $error("acknowledge byte does not match result kind");

  // A faulted byte never yields a result in the next cycle from an empty output.
  assert property (@(posedge clk) disable iff (rst)
      (accept && rx.rx_error && !frames.valid) |=> !frames.valid)
    else $error("result produced from a faulted byte");

endmodule

>>> design/sfr_crc8.sv
// One-byte update of the reflected CRC-8 (polynomial 0x91), fully combinational.
// Depends on sfr_pkg for the polynomial.
module sfr_crc8 import sfr_pkg::*; (
  input  logic [7:0] crc,
  input  logic [7:0] data,
  output logic [7:0] crc_next
);

  logic [7:0] acc;

  always_comb begin
    acc = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (acc[0]) begin
        acc = acc ^ CRC_POLY;
      end
      acc = {1'b0, acc[7:1]};
    end
    crc_next = acc;
  end

endmodule

>>> design/sfr_deframer.sv
// Frame state machine: hunts for the start marker, holds type and length,
// tracks the payload CRC and forms one result per payload or check byte.
// Depends on sfr_pkg and sfr_crc8.
module sfr_deframer import sfr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  logic [7:0] rx_byte,
  input  logic      rx_error,
  output logic      res_valid,
  output out_item_t res_item
);

  phase_t     phase, phase_next;
  logic [7:0] held_type;
  logic [7:0] held_length;
  logic [7:0] bytes_seen;
  logic [7:0] running_crc;
  logic [7:0] crc_next;
  logic [7:0] bytes_seen_next;

  sfr_crc8 u_crc (
    .crc      (running_crc),
    .data     (rx_byte),
    .crc_next (crc_next)
  );

  assign bytes_seen_next = bytes_seen + 8'd1;

  always_comb begin
    phase_next = phase;
    if (accept) begin
      if (rx_error) begin
        phase_next = PH_HUNT;
      end else begin
        unique case (phase)
          PH_TYPE:    phase_next = PH_LEN;
          PH_LEN:     phase_next = (rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
          PH_PAYLOAD: phase_next = (bytes_seen_next == held_length) ? PH_CHECK : PH_PAYLOAD;
          PH_CHECK:   phase_next = PH_HUNT;
          default:    phase_next = (rx_byte == START_MARK) ? PH_TYPE : PH_HUNT;
        endcase
      end
    end
  end

  always_comb begin
    res_valid             = 1'b0;
    res_item.kind         = KIND_PAYLOAD;
    res_item.data_byte    = 8'd0;
    res_item.frame_type   = held_type;
    res_item.frame_length = held_length;
    res_item.ack_byte     = 8'd0;
    res_item.last         = 1'b0;
    if (accept && !rx_error) begin
      unique case (phase)
        PH_PAYLOAD: begin
          res_valid          = 1'b1;
          res_item.data_byte = rx_byte;
        end
        PH_CHECK: begin
          res_valid     = 1'b1;
          res_item.last = 1'b1;
          if (rx_byte == running_crc) begin
            res_item.kind     = KIND_GOOD;
            res_item.ack_byte = ACK_GOOD;
          end else begin
            res_item.kind     = KIND_BAD;
            res_item.ack_byte = ACK_BAD;
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      held_type   <= 8'd0;
      held_length <= 8'd0;
      bytes_seen  <= 8'd0;
      running_crc <= 8'd0;
    end else begin
      phase <= phase_next;
      if (accept && !rx_error) begin
        if (phase == PH_TYPE) begin
          held_type <= rx_byte;
        end
        if (phase == PH_LEN) begin
          held_length <= rx_byte;
          bytes_seen  <= 8'd0;
          running_crc <= 8'd0;
        end
        if (phase == PH_PAYLOAD) begin
          bytes_seen  <= bytes_seen_next;
          running_crc <= crc_next;
        end
      end
    end
  end

endmodule

>>> design/sfr_out_buf.sv
// Result register with a skid stage, so the input side keeps taking bytes
// while one finished result waits. Depends on sfr_pkg and sfr_out_if.
module sfr_out_buf import sfr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  out_item_t in_item,
  output logic      in_ready,
  sfr_out_if.source res
);

  logic      main_valid;
  out_item_t main;
  logic      skid_valid;
  out_item_t skid;
  logic      take;

  assign take     = res.valid && res.ready;
  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || take) begin
      // The main register frees up: the skid entry moves first, then new data.
      if (skid_valid) begin
        main       <= skid;
        main_valid <= 1'b1;
        skid_valid <= in_valid;
        skid       <= in_item;
      end else begin
        main_valid <= in_valid;
        main       <= in_item;
      end
    end else if (in_valid) begin
      skid_valid <= 1'b1;
      skid       <= in_item;
    end
  end

  assign res.valid        = main_valid;
  assign res.kind         = main.kind;
  assign res.data_byte    = main.data_byte;
  assign res.frame_type   = main.frame_type;
  assign res.frame_length = main.frame_length;
  assign res.ack_byte     = main.ack_byte;
  assign res.last         = main.last;

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for serial_frame_receiver_crc8: directed frames, then random frames
// with CRC-8 check bytes, under varying sender gaps and receiver stalls.
// Depends on sfr_pkg, sfr_in_if, sfr_out_if and the receiver RTL.
module tb_top;
  import sfr_pkg::*;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_error;
    logic       typed;    // expected result written into the row by hand
    logic       has_res;
    out_item_t  want;
  } stim_t;

  localparam out_item_t NO_RES = '{KIND_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0};

  localparam stim_t DIRECTED [25] = '{
    // While hunting, a stray byte and a marker with a receive error are both dropped.
    '{8'ha5, 1'b0, 1'b1, 1'b0, NO_RES},
    '{START_MARK, 1'b1, 1'b1, 1'b0, NO_RES},
    // Empty payload: the check byte is compared with zero.
    '{START_MARK, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'hff, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b1, 1'b1, '{KIND_GOOD, 8'h00, 8'hff, 8'h00, ACK_GOOD, 1'b1}},
    // The marker value in the type and check positions is plain data.
    '{START_MARK, 1'b0, 1'b1, 1'b0, NO_RES},
    '{START_MARK, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h01, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b1, 1'b1, '{KIND_PAYLOAD, 8'h00, START_MARK, 8'h01, 8'h00, 1'b0}},
    '{START_MARK, 1'b0, 1'b1, 1'b1, '{KIND_BAD, 8'h00, START_MARK, 8'h01, ACK_BAD, 1'b1}},
    // A receive error on the length byte sends the block back to hunting.
    '{START_MARK, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h12, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h34, 1'b1, 1'b1, 1'b0, NO_RES},
    '{8'h12, 1'b0, 1'b1, 1'b0, NO_RES},
    // Marker value inside the payload; the verdict comes from the predictor.
    '{START_MARK, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h02, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'hff, 1'b0, 1'b1, 1'b1, '{KIND_PAYLOAD, 8'hff, 8'h00, 8'h02, 8'h00, 1'b0}},
    '{START_MARK, 1'b0, 1'b1, 1'b1, '{KIND_PAYLOAD, START_MARK, 8'h00, 8'h02, 8'h00, 1'b0}},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
    // A receive error where the check byte is due gives no verdict.
    '{START_MARK, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'hc3, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h77, 1'b1, 1'b1, 1'b0, NO_RES}
  };

  localparam int IDLE_PCT [4]  = '{0, 64, 0, 31};
  localparam int STALL_PCT [4] = '{0, 0, 64, 31};

  logic clk = 1'b0;
  logic rst = 1'b1;

  sfr_in_if  rx_ch ();
  sfr_out_if frames_ch ();

  serial_frame_receiver_crc8 dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .frames (frames_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  stim_t     bytes_to_send [$];
  out_item_t frames_due [$];
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        hold_left = 0;
  int        mismatches = 0;

  // Predictor state, mirroring the deframer.
  phase_t     rx_phase = PH_HUNT;
  logic [7:0] cur_type = 8'h00;
  logic [7:0] cur_len = 8'h00;
  logic [7:0] cur_count = 8'h00;
  logic [7:0] cur_crc = 8'h00;

  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) c = (c[0] ? (c ^ CRC_POLY) : c) >> 1;
    return c;
  endfunction

  // Advances the predictor by one received byte; returns 1 when a result is due.
  function automatic bit deframe_step(input logic [7:0] b, input logic err,
                                      output out_item_t r);
    r = NO_RES;
    if (err) begin
      rx_phase = PH_HUNT;
      return 1'b0;
    end
    case (rx_phase)
      PH_TYPE: begin
        cur_type = b;
        rx_phase = PH_LEN;
        return 1'b0;
      end
      PH_LEN: begin
        cur_len = b;
        cur_count = 8'h00;
        cur_crc = 8'h00;
        rx_phase = (b == 8'h00) ? PH_CHECK : PH_PAYLOAD;
        return 1'b0;
      end
      PH_PAYLOAD: begin
        cur_crc = crc8_fold(cur_crc, b);
        cur_count = cur_count + 8'd1;
        if (cur_count == cur_len) rx_phase = PH_CHECK;
        r = '{KIND_PAYLOAD, b, cur_type, cur_len, 8'h00, 1'b0};
        return 1'b1;
      end
      PH_CHECK: begin
        rx_phase = PH_HUNT;
        if (b == cur_crc) r = '{KIND_GOOD, 8'h00, cur_type, cur_len, ACK_GOOD, 1'b1};
        else r = '{KIND_BAD, 8'h00, cur_type, cur_len, ACK_BAD, 1'b1};
        return 1'b1;
      end
      default: begin
        rx_phase = (b == START_MARK) ? PH_TYPE : PH_HUNT;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic stim_t rx_item(input logic [7:0] b, input logic err);
    return '{b, err, 1'b0, 1'b0, NO_RES};
  endfunction

  // Queues some line noise and then one frame; a few frames are cut short by a
  // receive error. n counts the queued bytes.
  task automatic queue_frame(input int len, inout int n);
    stim_t      f [$];
    logic [7:0] b;
    logic [7:0] crc;
    int         cut;
    crc = 8'h00;
    repeat ($urandom_range(0, 2)) begin
      b = 8'($urandom);
      if (b == START_MARK && $urandom_range(7) != 0) b = ~b;
      f.push_back(rx_item(b, $urandom_range(5) == 0));
    end
    f.push_back(rx_item(START_MARK, 1'b0));
    f.push_back(rx_item(8'($urandom), 1'b0));
    f.push_back(rx_item(len[7:0], 1'b0));
    repeat (len) begin
      b = 8'($urandom);
      crc = crc8_fold(crc, b);
      f.push_back(rx_item(b, 1'b0));
    end
    f.push_back(rx_item(($urandom_range(3) != 0) ? crc : 8'($urandom), 1'b0));
    if ($urandom_range(9) == 0) begin
      cut = $urandom_range(0, f.size() - 1);
      f[cut].rx_error = 1'b1;
      while (f.size() > cut + 1) void'(f.pop_back());
    end
    n += f.size();
    foreach (f[i]) bytes_to_send.push_back(f[i]);
  endtask

  // Waits until every queued byte has been taken and the results have come back.
  task automatic settle();
    int guard;
    guard = 0;
    while (bytes_to_send.size() != 0 || rx_ch.valid) @(negedge clk);
    while (frames_due.size() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
  endtask

  initial begin
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = 8'h00;
    rx_ch.rx_error = 1'b0;
    frames_ch.ready = 1'b0;
  end

  // Sender: a byte is predicted at the edge where its transfer completes.
  always @(posedge clk) begin : rx_drive
    stim_t     cur;
    out_item_t res;
    bit        got;
    if (rx_ch.valid && rx_ch.ready) begin
      cur = bytes_to_send.pop_front();
      got = deframe_step(cur.rx_byte, cur.rx_error, res);
      if (cur.typed) begin
        got = cur.has_res;
        res = cur.want;
      end
      if (got) frames_due.push_back(res);
    end
    if (rst) begin
      rx_ch.valid <= 1'b0;
    end else if (rx_ch.valid && !rx_ch.ready) begin
      // The offered byte stays on the bus until it is taken.
    end else if (bytes_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
      rx_ch.valid <= 1'b1;
      rx_ch.rx_byte <= bytes_to_send[0].rx_byte;
      rx_ch.rx_error <= bytes_to_send[0].rx_error;
    end else begin
      rx_ch.valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    frames_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin : frames_check
    out_item_t got;
    out_item_t want;
    if (!rst && frames_ch.valid && frames_ch.ready) begin
      got = '{kind_t'(frames_ch.kind), frames_ch.data_byte, frames_ch.frame_type,
              frames_ch.frame_length, frames_ch.ack_byte, frames_ch.last};
      if (frames_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: kind=%0d data=%02h type=%02h len=%02h ack=%02h last=%0d",
                   got.kind, got.data_byte, got.frame_type, got.frame_length, got.ack_byte,
                   got.last);
        mismatches++;
      end else begin
        want = frames_due.pop_front();
        if (want.kind !== got.kind || want.data_byte !== got.data_byte ||
            want.frame_type !== got.frame_type || want.frame_length !== got.frame_length ||
            want.ack_byte !== got.ack_byte || want.last !== got.last) begin
          if (mismatches < 10) begin
            $write("mismatch: expected kind=%0d data=%02h type=%02h len=%02h ",
                   want.kind, want.data_byte, want.frame_type, want.frame_length);
            $write("ack=%02h last=%0d, ", want.ack_byte, want.last);
            $display("got kind=%0d data=%02h type=%02h len=%02h ack=%02h last=%0d",
                     got.kind, got.data_byte, got.frame_type, got.frame_length,
                     got.ack_byte, got.last);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin : run
    int n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (DIRECTED[i]) bytes_to_send.push_back(DIRECTED[i]);
    settle();
    for (int p = 0; p < 4; p++) begin
      idle_pct = IDLE_PCT[p];
      stall_pct = STALL_PCT[p];
      // A long receiver hold-off while bytes keep coming fills the result buffer.
      if (p == 0) hold_left = 300;
      n = 0;
      if (p == 3) queue_frame(255, n);
      while (n < 90) begin
        case ($urandom_range(9))
          0:       queue_frame(0, n);
          9:       queue_frame($urandom_range(9, 40), n);
          default: queue_frame($urandom_range(1, 8), n);
        endcase
      end
      settle();
    end
    repeat (16) @(negedge clk);
    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> files.f
design/sfr_pkg.sv
design/sfr_in_if.sv
design/sfr_out_if.sv
design/sfr_crc8.sv
design/sfr_deframer.sv
design/sfr_out_buf.sv
design/serial_frame_receiver_crc8.sv
tb/sv/tb_top.sv
